// File: hdl/slot_registry_free_list_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot registry
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef SLOT_REGISTRY_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define SLOT_REGISTRY_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication
`define SRFLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SRFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/srfla_pkg.sv
// ----------------------------------------------------------------------------
// srfla_pkg
// Types, codes and sizes shared by the slot registry front, back and top.
// ----------------------------------------------------------------------------
package srfla_pkg;

  localparam int SLOTS       = 1024;
  localparam int ID_W        = $clog2(SLOTS);
  localparam int OWNER_W     = 16;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int S_TDATA_W   = ((ID_W + OWNER_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((ID_W + OWNER_W + 7) / 8) * 8;
  localparam logic [ID_W-1:0] FRESH_LIMIT = ID_W'(SLOTS - 1);

  // Request kinds as they arrive on the bus
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // Internal operation after classification
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_LOOKUP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_FREE_IGNORED = 2'd2,
    ST_LOOKUP_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // Classified request as it sits in the queue
  typedef struct packed {
    op_t               op;
    logic              id_zero;
    logic [ID_W-1:0]   slot_id;
    logic [OWNER_W-1:0] owner;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// File: hdl/srfla_front.sv
// ----------------------------------------------------------------------------
// srfla_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module srfla_front
  import srfla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // slot_id, owner, zero pad
  input  logic [KIND_W-1:0]     s_tuser,  // kind
  output queue_head_t           head,
  input  logic                  pop
);

  `include "slot_registry_free_list_allocator_top_macros.svh"

  cmd_t       in_cmd;
  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // Classify: unknown kind reads as lookup
  always_comb begin
    in_cmd.slot_id = s_tdata[ID_W-1:0];
    in_cmd.owner   = s_tdata[ID_W +: OWNER_W];
    in_cmd.id_zero = (s_tdata[ID_W-1:0] == '0);
    case (s_tuser)
      KIND_ALLOC: in_cmd.op = OP_ALLOC;
      KIND_FREE:  in_cmd.op = OP_FREE;
      default:    in_cmd.op = OP_LOOKUP;
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_cmd;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd   = entry[rd_ptr];

  `SRFLA_ASSERT_NOW(a_pop_nonempty, pop, count != 2'd0, "queue popped while empty")
  `SRFLA_ASSERT_NOW(a_count_range, 1'b1, count != 2'd3, "queue count out of range")

endmodule

// File: hdl/srfla_back.sv
// ----------------------------------------------------------------------------
// srfla_back
// Executes requests against slot and link memories; holds the result register.
// ----------------------------------------------------------------------------
module srfla_back
  import srfla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  queue_head_t           head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // given_id, owner_out, zero pad
  output logic [STATUS_W-1:0]   m_tuser   // status
);

  `include "slot_registry_free_list_allocator_top_macros.svh"

  // Slot memory entry: {occupied, owner}; link memory: next free id
  logic [OWNER_W:0]   slot_mem [SLOTS];
  logic [ID_W-1:0]    link_mem [SLOTS];

  back_state_t        state;
  back_state_t        state_next;
  cmd_t               cmd;
  logic [OWNER_W:0]   slot_rd;
  logic [ID_W-1:0]    link_rd;

  logic [ID_W-1:0]    fresh_count;
  logic [ID_W-1:0]    free_head;
  logic [ID_W-1:0]    free_tail;
  logic               free_empty;

  logic               commit;
  logic               occ;
  logic               fresh_avail;
  logic [ID_W-1:0]    got;
  logic [ID_W-1:0]    res_id;
  logic [OWNER_W-1:0] res_owner;
  status_t            res_status;
  logic               slot_we;
  logic [ID_W-1:0]    slot_wa;
  logic [OWNER_W:0]   slot_wd;
  logic               link_we;

  logic [ID_W-1:0]    out_id;
  logic [OWNER_W-1:0] out_owner;
  status_t            out_status;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    commit     = 1'b0;
    case (state)
      BK_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Latch the request and read both memories
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd     <= head.cmd;
      slot_rd <= slot_mem[head.cmd.slot_id];
      link_rd <= link_mem[free_head];
    end
  end

  // Ids above the fresh count were never written, so they read as empty
  assign occ = slot_rd[OWNER_W] && !cmd.id_zero && (cmd.slot_id <= fresh_count);
  assign fresh_avail = (fresh_count != FRESH_LIMIT);
  assign got = fresh_avail ? (fresh_count + ID_W'(1)) : free_head;

  // Decide result and memory writes
  always_comb begin
    res_id     = cmd.slot_id;
    res_owner  = '0;
    res_status = ST_OK;
    slot_we    = 1'b0;
    slot_wa    = cmd.slot_id;
    slot_wd    = {1'b0, cmd.owner};
    link_we    = 1'b0;
    case (cmd.op)
      OP_ALLOC: begin
        if (!fresh_avail && free_empty) begin
          res_id     = '0;
          res_status = ST_FULL;
        end else begin
          res_id  = got;
          slot_we = commit;
          slot_wa = got;
          slot_wd = {1'b1, cmd.owner};
        end
      end
      OP_FREE: begin
        if (occ) begin
          slot_we = commit;
          link_we = commit && !free_empty;
        end else begin
          res_status = ST_FREE_IGNORED;
        end
      end
      default: begin
        if (occ) begin
          res_owner = slot_rd[OWNER_W-1:0];
        end else begin
          res_status = ST_LOOKUP_EMPTY;
        end
      end
    endcase
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (link_we) begin
      link_mem[free_tail] <= cmd.slot_id;
    end
  end

  // Fresh counter and free list pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_count <= '0;
      free_head   <= '0;
      free_tail   <= '0;
      free_empty  <= 1'b1;
    end else if (commit) begin
      if (cmd.op == OP_ALLOC && res_status == ST_OK) begin
        if (fresh_avail) begin
          fresh_count <= got;
        end else if (free_head == free_tail) begin
          free_empty <= 1'b1;
        end else begin
          free_head <= link_rd;
        end
      end
      if (cmd.op == OP_FREE && occ) begin
        free_tail  <= cmd.slot_id;
        free_empty <= 1'b0;
        if (free_empty) begin
          free_head <= cmd.slot_id;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_id     <= res_id;
      out_owner  <= res_owner;
      out_status <= res_status;
    end
  end

  assign m_tdata = {{(M_TDATA_W - ID_W - OWNER_W){1'b0}}, out_owner, out_id};
  assign m_tuser = out_status;

  `SRFLA_ASSERT_NOW(a_full_exhausted, commit && res_status == ST_FULL,
    !fresh_avail && free_empty, "full reported while ids remain")
  `SRFLA_ASSERT_NOW(a_list_ids_nonzero, !free_empty,
    free_head != '0 && free_tail != '0, "free list holds id zero")
  `SRFLA_ASSERT_NOW(a_alloc_nonzero, commit && cmd.op == OP_ALLOC && res_status == ST_OK,
    got != '0, "allocate issued id zero")
  `SRFLA_ASSERT_NEXT(a_commit_shows, commit, m_tvalid, "committed result not presented")

endmodule

// File: hdl/slot_registry_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_registry_free_list_allocator_top
// Slot registry handing out ids with a FIFO free list linked in the slots.
// ----------------------------------------------------------------------------
// In the back end the idle state pops a request from the queue and reads
// the slot memory at its id and the link memory at the free-list head into
// registers; the exec state then decides, writes both memories and loads
// the result register once it is empty or being taken. The back end takes
// no new request until the last is through. A two-entry queue in front
// takes new requests while the back end works or while a result waits to
// be taken. Allocate issues 1, 2, ... up to SLOTS-1 first, then reuses
// freed ids oldest first; id 0 is never issued. Occupancy is masked by the
// fresh count: no clearing pass after reset; requests taken once rst falls.
module slot_registry_free_list_allocator_top
  import srfla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // slot_id, owner, zero pad
  input  logic [KIND_W-1:0]     s_tuser,  // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // given_id, owner_out, zero pad
  output logic [STATUS_W-1:0]   m_tuser   // status
);

  queue_head_t head;
  logic        pop;

  // Front: classify and queue
  srfla_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  // Back: execute and deliver results
  srfla_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: slot registry free-list allocator regression
// Drives allocate, free and lookup requests through the slave stream while
// a local copy of the registry predicts each reply. Replies from the master
// stream are checked in order against the predictions. The run covers fresh
// id issue in order, frees and their effect on later lookups, ignored frees
// of id zero, of empty slots and of unissued ids, lookups of empty slots and
// the spare kind. Sender bursts and receiver stalls vary.
// ----------------------------------------------------------------------------
module tb_top;
  import srfla_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;  // decoded as a lookup
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PAD_W = S_TDATA_W - ID_W - OWNER_W;
  localparam int FRESH_ITEMS = 330;
  localparam int MIX_ITEMS = 150;

  typedef struct {
    logic [ID_W-1:0]    given_id;
    logic [OWNER_W-1:0] owner_out;
    status_t            status;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // slot_id, owner, zero pad
  logic [KIND_W-1:0]    s_tuser = '0;  // kind
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // given_id, owner_out, zero pad
  logic [STATUS_W-1:0]  m_tuser;       // status

  slot_registry_free_list_allocator_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Registry copy used for prediction
  bit   [SLOTS-1:0]   in_use = '0;
  logic [OWNER_W-1:0] tag_store [SLOTS];
  logic [ID_W-1:0]    reuse_link [SLOTS];
  int                 issued_count = 0;
  logic [ID_W-1:0]    reuse_head = '0;
  logic [ID_W-1:0]    reuse_tail = '0;
  bit                 reuse_empty = 1'b1;

  reply_t replies_due [$];
  int     fail_count = 0;
  int     cycle_count = 0;
  int     burst_left = 0;
  int     stall_left = 0;
  int     stall_mode = 0;

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("slot_registry_free_list_allocator_top regression: fail");
      $finish;
    end
  end

  // Predict the reply of one request and update the registry copy
  function automatic reply_t registry_apply(logic [KIND_W-1:0] kind,
                                            logic [ID_W-1:0] id,
                                            logic [OWNER_W-1:0] owner);
    reply_t r;
    r.given_id  = id;
    r.owner_out = '0;
    r.status    = ST_OK;
    case (kind)
      KIND_ALLOC: begin
        r.given_id = '0;
        if (issued_count < int'(FRESH_LIMIT)) begin
          issued_count++;
          r.given_id = ID_W'(issued_count);
        end else if (!reuse_empty) begin
          r.given_id = reuse_head;
          if (reuse_head == reuse_tail) reuse_empty = 1'b1;
          else reuse_head = reuse_link[reuse_head];
        end else begin
          r.status = ST_FULL;
        end
        if (r.status == ST_OK) begin
          in_use[r.given_id]    = 1'b1;
          tag_store[r.given_id] = owner;
        end
      end
      KIND_FREE: begin
        if (id == '0 || int'(id) > issued_count || !in_use[id]) begin
          r.status = ST_FREE_IGNORED;
        end else begin
          in_use[id] = 1'b0;
          if (reuse_empty) begin
            reuse_head  = id;
            reuse_empty = 1'b0;
          end else begin
            reuse_link[reuse_tail] = id;
          end
          reuse_tail = id;
        end
      end
      default: begin
        // lookup, spare kind included
        if (in_use[id]) r.owner_out = tag_store[id];
        else r.status = ST_LOOKUP_EMPTY;
      end
    endcase
    return r;
  endfunction

  // Send one request; the sender may idle between bursts of random length
  task automatic send_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                              logic [OWNER_W-1:0] owner);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, owner, id};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    replies_due.push_back(registry_apply(kind, id, owner));
  endtask

  // Mostly an occupied id, otherwise any id
  function automatic logic [ID_W-1:0] pick_held_id();
    logic [ID_W-1:0] id;
    id = ID_W'($urandom_range(0, SLOTS - 1));
    for (int i = 0; i < 16 && issued_count > 0; i++) begin
      id = ID_W'($urandom_range(1, issued_count));
      if (in_use[id]) break;
    end
    return id;
  endfunction

  function automatic logic [OWNER_W-1:0] pick_owner();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return OWNER_W'($urandom_range(0, (1 << OWNER_W) - 1));
    endcase
  endfunction

  // Edge ids, ignored frees, lookups of empty and spare kind, first allocs
  task automatic test_directed();
    send_request(KIND_LOOKUP, '0, '0);
    send_request(KIND_FREE, '0, '1);
    send_request(KIND_FREE, '1, '0);
    send_request(KIND_SPARE, '1, '1);
    send_request(KIND_ALLOC, '1, '0);
    send_request(KIND_ALLOC, '0, '1);
    send_request(KIND_ALLOC, 10'h2aa, 16'h5a5a);
    send_request(KIND_LOOKUP, 10'd1, '0);
    send_request(KIND_LOOKUP, 10'd2, '1);
    send_request(KIND_SPARE, 10'd3, '0);
    send_request(KIND_FREE, 10'd2, '0);
    send_request(KIND_FREE, 10'd2, '0);
    send_request(KIND_LOOKUP, 10'd2, '0);
    send_request(KIND_FREE, 10'd4, '0);
    send_request(KIND_FREE, 10'd1, 16'ha5a5);
    send_request(KIND_FREE, 10'd3, '0);
    send_request(KIND_ALLOC, 10'h155, 16'h8001);
    send_request(KIND_LOOKUP, 10'd4, '0);
    send_request(KIND_LOOKUP, '1, '0);
    send_request(KIND_SPARE, 10'd1, '0);
  endtask

  // Allocate-heavy random traffic through the fresh range
  task automatic test_fresh_exhaust(int count);
    int pick;
    for (int n = 0; n < count && issued_count < int'(FRESH_LIMIT); n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85)
        send_request(KIND_ALLOC, ID_W'($urandom_range(0, SLOTS - 1)), pick_owner());
      else if (pick < 95)
        send_request(KIND_FREE, pick_held_id(), pick_owner());
      else
        send_request(($urandom_range(0, 1) == 0) ? KIND_LOOKUP : KIND_SPARE,
                     pick_held_id(), pick_owner());
    end
  endtask

  // Random mix of allocates, frees and lookups, stray ids included
  task automatic test_reuse_mix(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_request(KIND_ALLOC, ID_W'($urandom_range(0, SLOTS - 1)), pick_owner());
      else if (pick < 67)
        send_request(KIND_FREE, pick_held_id(), pick_owner());
      else if (pick < 75)
        send_request(KIND_FREE, ID_W'($urandom_range(0, SLOTS - 1)), pick_owner());
      else if (pick < 92)
        send_request(KIND_LOOKUP, pick_held_id(), pick_owner());
      else
        send_request(KIND_SPARE, ID_W'($urandom_range(0, SLOTS - 1)), pick_owner());
    end
  endtask

  // Reply checker and receiver stall pattern
  always @(posedge clk) begin : reply_check
    reply_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply with none pending: given_id %0d status %0d",
               m_tdata[ID_W-1:0], m_tuser);
        fail_count++;
      end else begin
        due = replies_due.pop_front();
        if (m_tdata[ID_W-1:0] !== due.given_id) begin
          $error("given_id: expected %0d, actual %0d", due.given_id, m_tdata[ID_W-1:0]);
          fail_count++;
        end
        if (m_tdata[ID_W +: OWNER_W] !== due.owner_out) begin
          $error("owner_out: expected %0h, actual %0h", due.owner_out,
                 m_tdata[ID_W +: OWNER_W]);
          fail_count++;
        end
        if (m_tuser !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, m_tuser);
          fail_count++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Sequence of tests
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fresh_exhaust(FRESH_ITEMS);
    test_reuse_mix(MIX_ITEMS);
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("slot_registry_free_list_allocator_top regression: pass");
    end else begin
      $display("slot_registry_free_list_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
